// ===== sv/pqdt_pkg.sv =====
package pqdt_pkg;

    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int PROD_W = 32;
    localparam int TIMER_W = 26;
    localparam int LEN_W  = 24;

    localparam int TICKS_PER_SECOND_DEF = 1000;
    localparam int PULSE_COUNT_BITS_DEF = 24;

    localparam logic [CFG_W-1:0]  MIN_PULSE_RESET = 16'd1900;
    localparam logic [PROD_W-1:0] TIMER_MAX       = 32'h03FF_FFFF;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_MIN_PULSE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX_DEBOUNCE = 3'd2;
    localparam logic [IDX_W-1:0] REG_POWER_DELAY  = 3'd3;
    localparam logic [IDX_W-1:0] REG_POWER_ON     = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_DELAY = 3'b010,
        PH_ON    = 3'b100
    } phase_t;

    // settings as the timers use them: seconds already scaled to ticks
    typedef struct packed {
        logic [CFG_W-1:0]   min_pulse;
        logic [TIMER_W-1:0] debounce_ticks;
        logic [TIMER_W-1:0] max_debounce_ticks;
        logic [TIMER_W-1:0] delay_ticks;
        logic [TIMER_W-1:0] on_ticks;
    } cfg_t;

    typedef struct packed {
        logic               debounce_waiting;
        logic               pulse_accepted;
        logic [LEN_W-1:0]   pulse_length;
        logic               pulse_done;
        logic               send_request;
        logic               output_level;
    } res_t;

endpackage

// ===== sv/pqdt_cfg.sv =====
module pqdt_cfg
    import pqdt_pkg::*;
#(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output cfg_t             cfg
);

    logic [PROD_W-1:0]  prod;
    logic [TIMER_W-1:0] ticks;
    cfg_t               cfg_reg;

    // seconds to ticks, saturated to the timer width; the result is stored on a write
    assign prod  = PROD_W'(cfg_wdata) * PROD_W'(TICKS_PER_SECOND);
    assign ticks = (prod > TIMER_MAX) ? {TIMER_W{1'b1}} : prod[TIMER_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_pulse          <= MIN_PULSE_RESET;
            cfg_reg.debounce_ticks     <= '0;
            cfg_reg.max_debounce_ticks <= '0;
            cfg_reg.delay_ticks        <= '0;
            cfg_reg.on_ticks           <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MIN_PULSE:    cfg_reg.min_pulse          <= cfg_wdata;
                REG_DEBOUNCE:     cfg_reg.debounce_ticks     <= ticks;
                REG_MAX_DEBOUNCE: cfg_reg.max_debounce_ticks <= ticks;
                REG_POWER_DELAY:  cfg_reg.delay_ticks        <= ticks;
                REG_POWER_ON:     cfg_reg.on_ticks           <= ticks;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/pqdt_core.sv =====
module pqdt_core
    import pqdt_pkg::*;
#(
    parameter int PULSE_COUNT_BITS = PULSE_COUNT_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic pin_level,
    input  cfg_t cfg,
    output res_t res
);

    localparam int CNT_W = PULSE_COUNT_BITS;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] power_left_reg, power_left_next;
    logic               running_reg, running_next;
    logic [TIMER_W-1:0] db_left_reg, db_left_next;
    logic [TIMER_W-1:0] since_reg, since_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pin_prev_reg;
    logic [LEN_W-1:0]   cnt_len;

    generate
        if (CNT_W > LEN_W)
        begin : g_len_sat
            assign cnt_len = (|cnt_reg[CNT_W-1:LEN_W]) ? {LEN_W{1'b1}}
                                                       : cnt_reg[LEN_W-1:0];
        end
        else
        begin : g_len_ext
            assign cnt_len = LEN_W'(cnt_reg);
        end
    endgenerate

    always_comb
    begin
        phase_next      = phase_reg;
        power_left_next = power_left_reg;
        running_next    = running_reg;
        db_left_next    = db_left_reg;
        since_next      = since_reg;
        cnt_next        = cnt_reg;
        res             = '0;

        // power sequence
        unique case (phase_reg)
            PH_DELAY:
            begin
                if (power_left_reg <= TIMER_W'(1))
                begin
                    phase_next      = PH_ON;
                    power_left_next = cfg.on_ticks;
                end
                else
                    power_left_next = power_left_reg - TIMER_W'(1);
            end
            PH_ON:
            begin
                if (power_left_reg <= TIMER_W'(1))
                begin
                    phase_next      = PH_IDLE;
                    power_left_next = '0;
                end
                else
                    power_left_next = power_left_reg - TIMER_W'(1);
            end
            default: phase_next = PH_IDLE;
        endcase

        // debounce wait
        if (running_reg)
        begin
            if (since_reg != {TIMER_W{1'b1}})
                since_next = since_reg + TIMER_W'(1);
            if (db_left_reg <= TIMER_W'(1))
            begin
                running_next     = 1'b0;
                db_left_next     = '0;
                phase_next       = PH_DELAY;
                power_left_next  = cfg.delay_ticks;
                res.send_request = 1'b1;
            end
            else
                db_left_next = db_left_reg - TIMER_W'(1);
        end

        // pulse timing; acts on the state left by the timers above
        if (pin_level)
        begin
            if (cnt_reg != {CNT_W{1'b1}})
                cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pin_prev_reg)
        begin
            res.pulse_done   = 1'b1;
            res.pulse_length = cnt_len;
            cnt_next         = '0;
            if ((CMP_W'(cnt_reg) > CMP_W'(cfg.min_pulse)) && (phase_next == PH_IDLE))
            begin
                res.pulse_accepted = 1'b1;
                if (running_next)
                begin
                    if (since_next > cfg.max_debounce_ticks)
                    begin
                        running_next     = 1'b0;
                        db_left_next     = '0;
                        phase_next       = PH_DELAY;
                        power_left_next  = cfg.delay_ticks;
                        res.send_request = 1'b1;
                    end
                    else
                        db_left_next = cfg.debounce_ticks;
                end
                else
                begin
                    since_next = '0;
                    if (cfg.debounce_ticks == '0)
                    begin
                        phase_next       = PH_DELAY;
                        power_left_next  = cfg.delay_ticks;
                        res.send_request = 1'b1;
                    end
                    else
                    begin
                        running_next = 1'b1;
                        db_left_next = cfg.debounce_ticks;
                    end
                end
            end
        end
        else
            cnt_next = '0;

        res.output_level     = (phase_next == PH_ON);
        res.debounce_waiting = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            power_left_reg <= '0;
            running_reg    <= 1'b0;
            db_left_reg    <= '0;
            since_reg      <= '0;
            cnt_reg        <= '0;
            pin_prev_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            power_left_reg <= power_left_next;
            running_reg    <= running_next;
            db_left_reg    <= db_left_next;
            since_reg      <= since_next;
            cnt_reg        <= cnt_next;
            pin_prev_reg   <= pin_level;
        end
    end

endmodule

// ===== sv/pulse_qualified_debounced_trigger_unit.sv =====
// Pulse qualified debounced trigger.
// Input stream: one beat per timer tick, s_axis_tdata[0] is the sensor pin level.
// Output stream: one beat per input beat with the output drive level, the send
// strobe, the end-of-pulse report with its length, the accepted flag and the
// debounce-wait flag.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one 16-bit register per
// clock; timer settings are in seconds and scaled to ticks on the write.
// Each output beat is registered from its input beat. Throughput is one beat per
// cycle unless the receiver stalls: each tick's state update is a single pass of
// counters and compares, and the result sits in a one-beat output register.
// When the receiver stalls the output beat is held and the input is still taken
// in the same cycle the held beat leaves; otherwise s_axis_tready drops.
// Reset clears all timers and the pulse counter, sets the minimum pulse length
// to 1900 ticks and every other register to zero, and empties the output.
module pulse_qualified_debounced_trigger_unit
    import pqdt_pkg::*;
#(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
    parameter int PULSE_COUNT_BITS = PULSE_COUNT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [0] pin_level
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [0] output_level, [1] send_request,
                                             // [2] pulse_done, [26:3] pulse_length,
                                             // [27] pulse_accepted, [28] debounce_waiting
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cfg_t cfg;
    res_t res;
    res_t out_data_reg;
    logic out_valid_reg;
    logic step;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    pqdt_cfg #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg)
    );

    pqdt_core #(
        .PULSE_COUNT_BITS(PULSE_COUNT_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .pin_level(s_axis_tdata[0]),
        .cfg      (cfg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_axis_tready)
            out_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 32'(out_data_reg);

endmodule

// ===== verif/tb_pulse_qualified_debounced_trigger_unit.sv =====
`timescale 1ns / 100ps

module tb_pulse_qualified_debounced_trigger_unit;
    import pqdt_pkg::*;

    // indexes outside the register map, written to show they are ignored
    localparam logic [IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;    // [0] pin_level
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [31:0]      m_axis_tdata;         // [0] output_level, [1] send_request,
                                            // [2] pulse_done, [26:3] pulse_length,
                                            // [27] pulse_accepted, [28] debounce_waiting
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    pulse_qualified_debounced_trigger_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // register copies as written: minimum pulse in ticks, timer settings in seconds
    logic [CFG_W-1:0] cfg_min_pulse      = MIN_PULSE_RESET;
    logic [CFG_W-1:0] cfg_debounce_s     = '0;
    logic [CFG_W-1:0] cfg_max_debounce_s = '0;
    logic [CFG_W-1:0] cfg_delay_s        = '0;
    logic [CFG_W-1:0] cfg_on_s           = '0;

    // trigger state as the block should hold it
    logic                            pin_was_high = 1'b0;
    logic [PULSE_COUNT_BITS_DEF-1:0] pulse_ticks  = '0;
    logic                            wait_active  = 1'b0;
    logic [TIMER_W-1:0]              wait_left    = '0;
    logic [TIMER_W-1:0]              wait_elapsed = '0;
    phase_t                          pwr_phase    = PH_IDLE;
    logic [TIMER_W-1:0]              pwr_left     = '0;

    res_t tick_reports_due[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned pulses_ended = 0;
    int unsigned pulses_taken = 0;
    int unsigned triggers_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [TIMER_W-1:0] to_ticks(input logic [CFG_W-1:0] secs);
        logic [PROD_W-1:0] t;
        t = PROD_W'(secs) * PROD_W'(TICKS_PER_SECOND_DEF);
        return (t > TIMER_MAX) ? TIMER_MAX[TIMER_W-1:0] : t[TIMER_W-1:0];
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            REG_MIN_PULSE:    cfg_min_pulse = val;
            REG_DEBOUNCE:     cfg_debounce_s = val;
            REG_MAX_DEBOUNCE: cfg_max_debounce_s = val;
            REG_POWER_DELAY:  cfg_delay_s = val;
            REG_POWER_ON:     cfg_on_s = val;
            default:          ;
        endcase
    endfunction

    function automatic void arm_power();
        pwr_phase = PH_DELAY;
        pwr_left = to_ticks(cfg_delay_s);
    endfunction

    // one tick: power timer, then debounce timer, then the pin
    function automatic res_t predict_tick(input logic pin);
        res_t r;
        r = '0;

        case (pwr_phase)
            PH_DELAY:
                if (pwr_left <= 1)
                begin
                    pwr_phase = PH_ON;
                    pwr_left = to_ticks(cfg_on_s);
                end
                else
                    pwr_left = pwr_left - 1'b1;
            PH_ON:
                if (pwr_left <= 1)
                begin
                    pwr_phase = PH_IDLE;
                    pwr_left = '0;
                end
                else
                    pwr_left = pwr_left - 1'b1;
            default:
                pwr_phase = PH_IDLE;
        endcase

        if (wait_active)
        begin
            if (wait_elapsed != {TIMER_W{1'b1}})
                wait_elapsed = wait_elapsed + 1'b1;
            if (wait_left <= 1)
            begin
                wait_active = 1'b0;
                wait_left = '0;
                arm_power();
                r.send_request = 1'b1;
            end
            else
                wait_left = wait_left - 1'b1;
        end

        if (pin)
        begin
            if (pulse_ticks != {PULSE_COUNT_BITS_DEF{1'b1}})
                pulse_ticks = pulse_ticks + 1'b1;
        end
        else if (pin_was_high)
        begin
            r.pulse_done = 1'b1;
            r.pulse_length = LEN_W'(pulse_ticks);
            // a pulse is only acted on while no output sequence is pending
            if (pulse_ticks > cfg_min_pulse && pwr_phase == PH_IDLE)
            begin
                r.pulse_accepted = 1'b1;
                if (wait_active)
                begin
                    if (wait_elapsed > to_ticks(cfg_max_debounce_s))
                    begin
                        wait_active = 1'b0;
                        wait_left = '0;
                        arm_power();
                        r.send_request = 1'b1;
                    end
                    else
                        wait_left = to_ticks(cfg_debounce_s);
                end
                else
                begin
                    wait_elapsed = '0;
                    if (cfg_debounce_s == '0)
                    begin
                        arm_power();
                        r.send_request = 1'b1;
                    end
                    else
                    begin
                        wait_active = 1'b1;
                        wait_left = to_ticks(cfg_debounce_s);
                    end
                end
            end
            pulse_ticks = '0;
        end
        else
            pulse_ticks = '0;

        pin_was_high = pin;
        r.output_level = (pwr_phase == PH_ON);
        r.debounce_waiting = wait_active;
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_beats
        res_t got;
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = res_t'(m_axis_tdata[28:0]);
            if (tick_reports_due.size() == 0)
            begin
                $error("output beat with no tick outstanding: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = tick_reports_due.pop_front();
                beats_checked++;
                pulses_ended += got.pulse_done;
                pulses_taken += got.pulse_accepted;
                triggers_seen += got.send_request;
                check_field("output_level", want.output_level, got.output_level);
                check_field("send_request", want.send_request, got.send_request);
                check_field("pulse_done", want.pulse_done, got.pulse_done);
                check_field("pulse_length", want.pulse_length, got.pulse_length);
                check_field("pulse_accepted", want.pulse_accepted, got.pulse_accepted);
                check_field("debounce_waiting", want.debounce_waiting, got.debounce_waiting);
                check_field("tdata padding", 0, m_axis_tdata[31:29]);
            end
        end
    end

    // tvalid is left high on return so back-to-back ticks need no second assignment
    task automatic send_tick(input logic pin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, pin};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tick_reports_due.push_back(predict_tick(pin));
        ticks_sent++;
    endtask

    task automatic send_pulse(input int unsigned high_ticks, input int unsigned low_ticks);
        repeat (high_ticks) send_tick(1'b1);
        repeat (low_ticks) send_tick(1'b0);
    endtask

    // quiet ticks until no sequence, wait or pulse is in progress
    task automatic settle();
        while (pwr_phase != PH_IDLE || wait_active || pin_was_high)
            send_tick(1'b0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tick_reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        apply_reg(idx, val);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] min_len, input logic [CFG_W-1:0] deb_s,
                              input logic [CFG_W-1:0] max_s, input logic [CFG_W-1:0] dly_s,
                              input logic [CFG_W-1:0] on_s);
        settle();
        drain();
        write_reg(REG_MIN_PULSE, min_len);
        write_reg(REG_DEBOUNCE, deb_s);
        write_reg(REG_MAX_DEBOUNCE, max_s);
        write_reg(REG_POWER_DELAY, dly_s);
        write_reg(REG_POWER_ON, on_s);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_threshold();
        // reset threshold: 1900 ticks is not enough, 1901 triggers at once
        send_pulse(1900, 2);
        send_pulse(1901, 3);
        settle();
    endtask

    task automatic test_pulse_qualification();
        set_config(16'd3, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pulse(1, 2);
        send_pulse(3, 2);
        send_pulse(4, 1);
        send_pulse(4, 3);
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_pulse(1, 1);
        send_pulse(1, 4);
        // output held on for a second; pulses in the meantime are dropped
        set_config(16'd3, 16'd0, 16'd0, 16'd0, 16'd1);
        send_pulse(4, 10);
        send_pulse(5, 3);
        settle();
    endtask

    task automatic test_debounce_wait();
        set_config(16'd3, 16'd1, 16'd2, 16'd0, 16'd0);
        send_pulse(4, 500);
        send_pulse(4, 1100);
        // second pulse ends on the very tick the wait expires
        send_pulse(4, 996);
        send_pulse(4, 3);
        // no grace on the overall limit: second pulse forces the trigger
        set_config(16'd3, 16'd1, 16'd0, 16'd0, 16'd0);
        send_pulse(4, 10);
        send_pulse(4, 3);
        set_config(16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_pulse(2, 2);
        send_pulse(2, 2);
        settle();
    endtask

    task automatic test_power_sequence();
        set_config(16'd3, 16'd0, 16'd0, 16'd1, 16'd1);
        send_pulse(4, 3);
        settle();
        set_config(16'd3, 16'd0, 16'd0, 16'd2, 16'd0);
        send_pulse(4, 3);
        settle();
    endtask

    task automatic test_register_extremes();
        set_config(16'd3, 16'd0, 16'd0, 16'd0, 16'd0);
        drain();
        write_reg(REG_SPARE_5, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'h0000);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        // spare writes leave the map alone: still an immediate trigger
        send_pulse(4, 3);
        settle();
        // full-scale timers: only pulses too short to qualify while these hold
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (6) send_pulse($urandom_range(1, 5), $urandom_range(1, 4));
        settle();
    endtask

    task automatic test_random_pulses(input int unsigned n_ticks, input int unsigned n_sets);
        int unsigned start;
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        logic [CFG_W-1:0] min_len;
        repeat (n_sets)
        begin
            min_len = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 6));
            set_config(min_len, CFG_W'($urandom_range(0, 1)), CFG_W'($urandom_range(0, 2)),
                       CFG_W'($urandom_range(0, 3) == 0), CFG_W'($urandom_range(0, 3) == 0));
            if (min_len > 32)
            begin
                lo = 1;
                hi = 8;
            end
            else
            begin
                lo = (min_len > 1) ? min_len - 1 : 1;
                hi = min_len + 3;
            end
            start = ticks_sent;
            while (ticks_sent - start < n_ticks / n_sets)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    send_pulse($urandom_range(lo, hi), $urandom_range(1, 12));
                else if (pick < 90)
                    send_pulse(1, $urandom_range(1, 3));
                else
                    send_pulse(0, $urandom_range(1, 40));
            end
        end
        settle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 26;
        recv_stall_pct = 53;
        test_reset_threshold();
        test_pulse_qualification();
        test_debounce_wait();
        test_power_sequence();
        test_register_extremes();
        test_random_pulses(350, 4);

        send_idle_pct = 53;
        recv_stall_pct = 26;
        test_random_pulses(350, 4);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_pulses(300, 3);

        drain();
        repeat (10) @(posedge clk);
        $display("%0d ticks sent, %0d beats checked", ticks_sent, beats_checked);
        $display("%0d pulses ended, %0d acted on, %0d triggers",
                 pulses_ended, pulses_taken, triggers_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("timeout with %0d ticks outstanding", tick_reports_due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
